// ----- rtl/markup_escape_translator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// markup escape translator assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef MARKUP_ESCAPE_TRANSLATOR_UNIT_DEFINES_SVH
`define MARKUP_ESCAPE_TRANSLATOR_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define MET_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds through reset
`define MET_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/met_pkg.sv -----
// ----------------------------------------------------------------------------
// met_pkg
// character codes, phase encoding and queue entry types of the translator
// ----------------------------------------------------------------------------
package met_pkg;

   localparam int MAX_OUT = 4;
   localparam int IDX_W   = 2;
   localparam int CNT_W   = 3;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_NL       = 3'd1,
      PH_NL_HASH  = 3'd2,
      PH_NL_DASH  = 3'd3,
      PH_DELETED  = 3'd4,
      PH_DEL_HASH = 3'd5
   } met_phase_type;

   // bytes produced by one input item, count is 1 to MAX_OUT
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] data;
      logic [CNT_W-1:0]        count;
   } met_group_type;

   typedef struct packed {
      logic          valid;
      met_group_type group;
   } met_push_type;

   typedef struct packed {
      logic          valid;
      met_group_type group;
   } met_head_type;

endpackage

// ----- rtl/met_req_if.sv -----
// ----------------------------------------------------------------------------
// met_req_if
// input channel: one text byte or an end-of-stream marker per word
// ----------------------------------------------------------------------------
interface met_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] in_byte;

   modport source (output valid, output action, output in_byte, input ready);
   modport sink   (input valid, input action, input in_byte, output ready);
endinterface

// ----- rtl/met_rsp_if.sv -----
// ----------------------------------------------------------------------------
// met_rsp_if
// result channel: one translated byte per word, last closes an input item
// ----------------------------------------------------------------------------
interface met_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ----- rtl/met_front.sv -----
// ----------------------------------------------------------------------------
// met_front
// accepts input words, tracks escape and line deletion state and builds the
// group of bytes each word produces
// ----------------------------------------------------------------------------
module met_front (
   input  logic                  clock,
   input  logic                  reset,
   met_req_if.sink               req_chan,
   input  logic                  queue_full,
   output met_pkg::met_push_type push
);
   import met_pkg::*;

   met_phase_type    phase_ff, phase_in;
   logic             pending_ff, pending_in;
   logic             accept;
   logic [7:0]       c;
   logic             c_nl, c_hash, c_dash;
   logic             nl_folds;
   logic             esc_hit, esc_keep;
   logic [7:0]       esc_sym;
   logic             r_fold, r_nl_hash, r_del_hash, r_dash, r_del_end, r_hash, r_esc;
   logic [MAX_OUT-1:0][7:0] pre_data;
   logic [CNT_W-1:0] pre_cnt;
   met_group_type    grp;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign c              = req_chan.in_byte;
   assign c_nl           = (c == CH_NL);
   assign c_hash         = (c == CH_HASH);
   assign c_dash         = (c == CH_DASH);

   // a newline folds into the held newline except inside a '#' or '#-' prefix
   assign nl_folds = !(phase_ff == PH_NL_HASH || phase_ff == PH_NL_DASH ||
                       phase_ff == PH_DEL_HASH);

   always_comb begin
      esc_hit  = 1'b1;
      esc_keep = 1'b0;
      esc_sym  = CH_HASH;
      case (c)
         CH_LBRK:  esc_sym = CH_LT;
         CH_RBRK:  esc_sym = CH_GT;
         CH_LPAR:  esc_sym = CH_AMP;
         CH_RPAR:  esc_sym = CH_SEMI;
         CH_TILDE: esc_sym = CH_HASH;
         CH_HASH:  esc_keep = 1'b1;
         default:  esc_hit = 1'b0;
      endcase
   end

   // rule chain, first match wins
   assign r_fold     = nl_folds && c_nl;
   assign r_nl_hash  = !r_fold && phase_ff == PH_NL && c_hash;
   assign r_del_hash = !r_fold && phase_ff == PH_DELETED && c_hash;
   assign r_dash     = (phase_ff == PH_NL_HASH || phase_ff == PH_DEL_HASH) && c_dash;
   assign r_del_end  = phase_ff == PH_NL_DASH && c_nl;
   assign r_hash     = !(r_fold || r_nl_hash || r_del_hash || r_dash || r_del_end) &&
                       !pending_ff && c_hash;
   assign r_esc      = !(r_fold || r_nl_hash || r_del_hash || r_dash || r_del_end) &&
                       pending_ff && esc_hit;

   // next state
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      if (accept) begin
         if (req_chan.action) begin
            phase_in   = PH_IDLE;
            pending_in = 1'b0;
         end else if (r_fold) begin
            phase_in   = PH_NL;
            pending_in = 1'b0;
         end else if (r_nl_hash) begin
            phase_in   = PH_NL_HASH;
            pending_in = 1'b1;
         end else if (r_del_hash) begin
            phase_in   = PH_DEL_HASH;
            pending_in = 1'b1;
         end else if (r_dash) begin
            phase_in   = PH_NL_DASH;
            pending_in = 1'b0;
         end else if (r_del_end) begin
            phase_in   = PH_DELETED;
            pending_in = 1'b0;
         end else if (r_hash) begin
            pending_in = 1'b1;
         end else if (r_esc) begin
            phase_in   = PH_IDLE;
            pending_in = esc_keep;
         end else begin
            phase_in   = PH_IDLE;
            pending_in = 1'b0;
         end
      end
   end

   // held-back prefix that a failed match or end of stream gives back
   always_comb begin
      pre_data = '0;
      pre_cnt  = '0;
      case (phase_ff)
         PH_NL: begin
            pre_data[0] = CH_NL;
            pre_cnt     = CNT_W'(1);
         end
         PH_NL_HASH: begin
            pre_data[0] = CH_NL;
            pre_data[1] = CH_HASH;
            pre_cnt     = CNT_W'(2);
         end
         PH_NL_DASH: begin
            pre_data[0] = CH_NL;
            pre_data[1] = CH_HASH;
            pre_data[2] = CH_DASH;
            pre_cnt     = CNT_W'(3);
         end
         default: begin
            if (pending_ff) begin
               pre_data[0] = CH_HASH;
               pre_cnt     = CNT_W'(1);
            end
         end
      endcase
   end

   // output group
   always_comb begin
      grp = '0;
      if (req_chan.action) begin
         grp.data  = pre_data;
         grp.count = pre_cnt;
      end else if (r_fold || r_nl_hash || r_del_hash || r_dash || r_del_end || r_hash) begin
         grp.count = '0;
      end else if (r_esc) begin
         if (phase_ff == PH_NL_HASH) begin
            grp.data[0] = CH_NL;
            grp.data[1] = esc_sym;
            grp.count   = CNT_W'(2);
         end else begin
            grp.data[0] = esc_sym;
            grp.count   = CNT_W'(1);
         end
      end else begin
         grp.data                   = pre_data;
         grp.data[pre_cnt[IDX_W-1:0]] = c;
         grp.count                  = pre_cnt + CNT_W'(1);
      end
   end

   assign push.valid = accept && (grp.count != '0);
   assign push.group = grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pending_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ----- rtl/met_queue.sv -----
// ----------------------------------------------------------------------------
// met_queue
// short fifo of byte groups between the front and the back
// ----------------------------------------------------------------------------
module met_queue #(
   parameter int Depth = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  met_pkg::met_push_type push,
   output logic                  full,
   output met_pkg::met_head_type head,
   input  logic                  pop
);
   import met_pkg::*;

   localparam int AW = $clog2(Depth);
   localparam int CW = $clog2(Depth + 1);

   met_group_type   entries_ff [Depth];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.group = entries_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/met_back.sv -----
// ----------------------------------------------------------------------------
// met_back
// walks the head group into the result register one byte per unstalled cycle
// ----------------------------------------------------------------------------
module met_back (
   input  logic                  clock,
   input  logic                  reset,
   input  met_pkg::met_head_type head,
   output logic                  pop,
   met_rsp_if.source             rsp_chan
);
   import met_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             load;
   logic             is_last;

   assign load    = !valid_ff || rsp_chan.ready;
   assign is_last = ({1'b0, idx_ff} == head.group.count - CNT_W'(1));
   assign pop     = load && head.valid && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = head.valid;
         byte_in  = head.group.data[idx_ff];
         last_in  = is_last;
         if (head.valid) begin
            idx_in = is_last ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.last     = last_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- rtl/markup_escape_translator_unit.sv -----
// ----------------------------------------------------------------------------
// markup_escape_translator_unit
// byte stream filter for two-character escapes and '#-' line deletion
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      word
//   req_chan  in    valid/ready    action, in_byte
//   rsp_chan  out   valid/ready    out_byte, last
//
// one input word per cycle while the group queue has room; the front settles
// state in the accept cycle and the back sends one result byte per cycle
// while rsp_chan is ready. a word gives 0 to 4 bytes, sent one at a time,
// so the sustained rate is one word per cycle while groups stay at one byte.
// each byte passes the group queue, then the output register of the back.
// synchronous reset clears the phase, the pending '#', the queue and rsp valid.
// ----------------------------------------------------------------------------
module markup_escape_translator_unit #(
   parameter int QueueDepth = 4
) (
   input  logic      clock,
   input  logic      reset,
   met_req_if.sink   req_chan,
   met_rsp_if.source rsp_chan
);
   import met_pkg::*;

   met_push_type push;
   met_head_type head;
   logic         queue_full;
   logic         pop;

   met_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   met_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   met_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- rtl/met_checker.sv -----
// ----------------------------------------------------------------------------
// met_checker
// port-level checks of the translator, bound to the top level
// ----------------------------------------------------------------------------
`include "markup_escape_translator_unit_defines.svh"

module met_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // a stalled result word holds
   `MET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last), "rsp word changed while stalled")

   // reset empties the output register
   `MET_ASSERT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid, "rsp valid after reset")

   // bytes of one group are offered back to back
   `MET_ASSERT_NEXT(a_group_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "gap inside a byte group")

   // an empty output stage means the queue has room
   `MET_ASSERT_IMPL(a_idle_ready, clock, reset, !rsp_valid, req_ready, "req stalled while rsp idle")

   // ready is known whenever a word is offered
   `MET_ASSERT_IMPL(a_req_known, clock, reset, req_valid, !$isunknown(req_ready), "req ready unknown")

endmodule

bind markup_escape_translator_unit met_checker u_met_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_last     (rsp_chan.last)
);

// ----- tb/tb_markup_escape_translator_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_markup_escape_translator_unit
// drives text bytes and end-of-stream words into the translator, checks each
// emitted byte and last flag against typed rows or a local model of the escape
// and line-deletion rules; random gaps on both channels, one long sink stall
// ----------------------------------------------------------------------------
module tb_markup_escape_translator_unit;
   import met_pkg::*;

   localparam logic ACT_DATA    = 1'b0;
   localparam logic ACT_EOS     = 1'b1;
   localparam int   RAND_WORDS  = 380;
   localparam int   HOLD_AT     = 100;
   localparam int   HOLD_CYCLES = 60;
   localparam int   STALL_LIMIT = 2000;
   localparam int   NUM_ROWS    = 32;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } xlat_word_type;

   typedef struct packed {
      logic            act;
      logic [7:0]      in_byte;
      logic            typed;
      logic [2:0]      cnt;
      logic [3:0][7:0] bytes;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   met_req_if req_if ();
   met_rsp_if rsp_if ();

   markup_escape_translator_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // local copy of the translator state
   met_phase_type line_phase = PH_IDLE;
   logic          hash_held  = 1'b0;
   logic [7:0]    emitted[$];
   xlat_word_type expected_words[$];

   int  mismatch_count = 0;
   int  rx_words       = 0;
   int  stall_cycles   = 0;
   bit  no_idle        = 1'b0;
   bit  sender_rush    = 1'b0;
   stim_row_type stim_rows [NUM_ROWS];

   function automatic void push_prefix(input met_phase_type ph, input logic held);
      case (ph)
         PH_NL: emitted.push_back(CH_NL);
         PH_NL_HASH: begin
            emitted.push_back(CH_NL);
            emitted.push_back(CH_HASH);
         end
         PH_NL_DASH: begin
            emitted.push_back(CH_NL);
            emitted.push_back(CH_HASH);
            emitted.push_back(CH_DASH);
         end
         default: if (held) emitted.push_back(CH_HASH);
      endcase
   endfunction

   // advance the translator state by one word; queue the bytes when record is set
   function automatic void translate_word(input logic act, input logic [7:0] c,
                                          input bit record);
      met_phase_type ph;
      logic          held;
      logic [7:0]    sym;
      ph   = line_phase;
      held = hash_held;
      emitted.delete();
      if (act == ACT_EOS) begin
         push_prefix(ph, held);
         line_phase = PH_IDLE;
         hash_held  = 1'b0;
      end else if ((ph inside {PH_IDLE, PH_NL, PH_DELETED}) && c == CH_NL) begin
         line_phase = PH_NL;
         hash_held  = 1'b0;
      end else if (ph == PH_NL && c == CH_HASH) begin
         line_phase = PH_NL_HASH;
         hash_held  = 1'b1;
      end else if (ph == PH_DELETED && c == CH_HASH) begin
         line_phase = PH_DEL_HASH;
         hash_held  = 1'b1;
      end else if ((ph == PH_NL_HASH || ph == PH_DEL_HASH) && c == CH_DASH) begin
         line_phase = PH_NL_DASH;
         hash_held  = 1'b0;
      end else if (ph == PH_NL_DASH && c == CH_NL) begin
         line_phase = PH_DELETED;
         hash_held  = 1'b0;
      end else if (!held && c == CH_HASH) begin
         hash_held = 1'b1;
      end else if (held && (c inside {CH_LBRK, CH_RBRK, CH_LPAR, CH_RPAR, CH_TILDE,
                                      CH_HASH})) begin
         case (c)
            CH_LBRK: sym = CH_LT;
            CH_RBRK: sym = CH_GT;
            CH_LPAR: sym = CH_AMP;
            CH_RPAR: sym = CH_SEMI;
            default: sym = CH_HASH;
         endcase
         if (ph == PH_NL_HASH) emitted.push_back(CH_NL);
         emitted.push_back(sym);
         // a doubled hash keeps the second one pending
         hash_held  = (c == CH_HASH);
         line_phase = PH_IDLE;
      end else begin
         push_prefix(ph, held);
         emitted.push_back(c);
         line_phase = PH_IDLE;
         hash_held  = 1'b0;
      end
      if (record) begin
         foreach (emitted[i])
            expected_words.push_back('{out_byte: emitted[i],
                                       last: (i == emitted.size() - 1)});
      end
   endfunction

   function automatic stim_row_type mk_row(input logic act, input logic [7:0] c,
                                           input int typed, input int cnt,
                                           input logic [7:0] b0 = 8'h00,
                                           input logic [7:0] b1 = 8'h00,
                                           input logic [7:0] b2 = 8'h00);
      stim_row_type r;
      r.act      = act;
      r.in_byte  = c;
      r.typed    = (typed != 0);
      r.cnt      = 3'(cnt);
      r.bytes[0] = b0;
      r.bytes[1] = b1;
      r.bytes[2] = b2;
      r.bytes[3] = 8'h00;
      return r;
   endfunction

   function automatic int draw_gap(input bit quiet);
      if (quiet) return 0;
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0: return CH_NL;
         1: return CH_HASH;
         2: return CH_DASH;
         3: return CH_LBRK;
         4: return CH_RBRK;
         5: return CH_LPAR;
         6: return CH_RPAR;
         7: return CH_TILDE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // returns in the time step of the accepting edge, valid left high
   task automatic send_word(input logic act, input logic [7:0] c, input bit predicted);
      int gap;
      gap = draw_gap(no_idle || sender_rush);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.action  <= act;
      req_if.in_byte <= c;
      do @(posedge clock); while (!req_if.ready);
      translate_word(act, c, predicted);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   initial begin
      int           sent;
      int           reps;
      bit           drained;
      stim_row_type row;
      logic [8:0]   chunk[$];
      sent    = 0;
      drained = 1'b0;
      req_if.valid   = 1'b0;
      req_if.action  = ACT_DATA;
      req_if.in_byte = 8'h00;

      stim_rows = '{
         mk_row(ACT_EOS,  8'hA5,    1, 0),
         mk_row(ACT_DATA, 8'h00,    1, 1, 8'h00),
         mk_row(ACT_DATA, 8'hFF,    1, 1, 8'hFF),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_LBRK,  1, 1, CH_LT),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_RBRK,  1, 1, CH_GT),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_LPAR,  1, 1, CH_AMP),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_RPAR,  1, 1, CH_SEMI),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_TILDE, 1, 1, CH_HASH),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_HASH,  1, 1, CH_HASH),
         // pending hash swallowed by the newline
         mk_row(ACT_DATA, CH_NL,    1, 0),
         mk_row(ACT_DATA, CH_NL,    1, 0),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_DASH,  1, 0),
         mk_row(ACT_DATA, CH_NL,    1, 0),
         // a second deleted line straight after the first
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_DASH,  1, 0),
         mk_row(ACT_DATA, CH_NL,    1, 0),
         mk_row(ACT_DATA, 8'h42,    1, 1, 8'h42),
         mk_row(ACT_DATA, CH_NL,    1, 0),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_DASH,  1, 0),
         mk_row(ACT_EOS,  8'h5A,    1, 3, CH_NL, CH_HASH, CH_DASH),
         mk_row(ACT_DATA, CH_NL,    1, 0),
         mk_row(ACT_DATA, CH_HASH,  1, 0),
         mk_row(ACT_DATA, CH_HASH,  0, 0),
         mk_row(ACT_EOS,  8'h00,    0, 0)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = stim_rows[i];
         send_word(row.act, row.in_byte, !row.typed);
         if (row.typed) begin
            for (int k = 0; k < row.cnt; k++)
               expected_words.push_back('{out_byte: row.bytes[k], last: (k == row.cnt - 1)});
         end
      end

      while (sent < RAND_WORDS) begin
         if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
         chunk.delete();
         case ($urandom_range(0, 9))
            0, 1, 2: chunk.push_back({ACT_DATA, 8'($urandom_range(0, 255))});
            3, 4: begin
               chunk.push_back({ACT_DATA, CH_HASH});
               chunk.push_back({ACT_DATA, pick_byte()});
            end
            5, 6: begin
               // deleted line, possibly followed by more
               chunk.push_back({ACT_DATA, CH_NL});
               reps = $urandom_range(1, 3);
               repeat (reps) begin
                  chunk.push_back({ACT_DATA, CH_HASH});
                  chunk.push_back({ACT_DATA, CH_DASH});
                  chunk.push_back({ACT_DATA, CH_NL});
               end
               chunk.push_back({ACT_DATA, pick_byte()});
            end
            7: begin
               // broken prefix
               chunk.push_back({ACT_DATA, CH_NL});
               if ($urandom_range(0, 3) != 0) chunk.push_back({ACT_DATA, CH_HASH});
               if ($urandom_range(0, 1) != 0) chunk.push_back({ACT_DATA, CH_DASH});
               if ($urandom_range(0, 2) == 0)
                  chunk.push_back({ACT_EOS, 8'($urandom_range(0, 255))});
               else
                  chunk.push_back({ACT_DATA, pick_byte()});
            end
            8: begin
               reps = $urandom_range(1, 4);
               repeat (reps) chunk.push_back({ACT_DATA, CH_NL});
            end
            default: chunk.push_back({ACT_EOS, 8'($urandom_range(0, 255))});
         endcase
         foreach (chunk[k]) send_word(chunk[k][8], chunk[k][7:0], 1'b1);
         sent += chunk.size();
         if (!drained && sent >= RAND_WORDS / 2) begin
            drained = 1'b1;
            drain_results();
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("markup_escape_translator_unit test passed");
      else
         $display("markup_escape_translator_unit test failed");
      $finish;
   end

   // result sink with random stalls and one long hold-off
   initial begin
      int            gap;
      bit            hold_done;
      xlat_word_type want;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rx_words == HOLD_AT && !hold_done) begin
            hold_done   = 1'b1;
            sender_rush = 1'b1;
            gap         = HOLD_CYCLES;
         end else begin
            gap = draw_gap(no_idle);
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         sender_rush = 1'b0;
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         rx_words++;
         if (expected_words.size() == 0) begin
            $error("unexpected word out_byte=%h last=%b", rsp_if.out_byte, rsp_if.last);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_if.out_byte !== want.out_byte) begin
               $error("out_byte expected %h actual %h", want.out_byte, rsp_if.out_byte);
               mismatch_count++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last expected %b actual %b", want.last, rsp_if.last);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("markup_escape_translator_unit test failed");
            $finish;
         end
      end
   end

endmodule
